// ===== design/dag_pkg.sv =====
package dag_pkg;

  // Default curve table depth
  localparam int CURVE_DEPTH_DEF = 16;

  // Fixed-point constants
  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // Gain model codes
  localparam logic [2:0] MODEL_NONE    = 3'd0;
  localparam logic [2:0] MODEL_LINEAR  = 3'd1;
  localparam logic [2:0] MODEL_INVERSE = 3'd2;
  localparam logic [2:0] MODEL_EXP     = 3'd3;
  localparam logic [2:0] MODEL_CUSTOM  = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_MODEL   = 3'd0;
  localparam logic [2:0] REG_NEAR    = 3'd1;
  localparam logic [2:0] REG_FAR     = 3'd2;
  localparam logic [2:0] REG_ROLLOFF = 3'd3;
  localparam logic [2:0] REG_COUNT   = 3'd4;

  // Serial divider geometry
  localparam int NUM_W = 48;  // dividend width
  localparam int DEN_W = 42;  // divisor width
  localparam int QS    = 19;  // quotient bits, short divide
  localparam int QL    = 32;  // quotient bits, long divide

  // Divider request
  typedef struct packed {
    logic start;
    logic long_op;
  } div_req_t;

endpackage

// ===== design/distance_attenuation_gain.sv =====
// Distance attenuation gain.
// Input channel (in_valid/in_ready): one beat is either an evaluate item
// (in_action = 0) carrying a Q16.8 distance, or a curve write (in_action = 1)
// that stores one point of the custom table. A write gives no result.
// Result channel (out_valid/out_ready): one Q1.15 gain per evaluate beat.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index picks
// model, near limit, far limit, rolloff or curve count; write only when idle.
// Items are handled one at a time. Every step of a serial divider yields one
// quotient bit. Outside the limits or under model none no divide is run;
// linear and inverse distance use one short divide, a custom table walks its
// points and then uses a short divide, and exponential runs a short divide
// and then ten series terms, each a 32-step divide.
// The result sits in an output register, so a stalled receiver holds at most
// one gain; the next item is then taken but its result waits until the held
// beat leaves.
// Reset (synchronous, rst_n low) restores the register defaults: inverse
// distance, near 1.0, far 100.0, rolloff 1.0, empty curve. Table contents
// are undefined until written.
module distance_attenuation_gain import dag_pkg::*; #(
  parameter int CURVE_DEPTH = CURVE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [23:0] in_distance_in,
  input  logic [3:0]  in_point_index,
  input  logic [15:0] in_point_gain,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_gain_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int AW   = (CURVE_DEPTH > 1) ? $clog2(CURVE_DEPTH) : 1;
  localparam int CW0  = $clog2(CURVE_DEPTH + 1);
  localparam int CNTW = (CW0 > 5) ? CW0 : 5;

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_DISP  = 20'h00002,
    S_INV   = 20'h00004,
    S_INV2  = 20'h00008,
    S_DIVG  = 20'h00010,
    S_DIVX  = 20'h00020,
    S_EY    = 20'h00040,
    S_TM    = 20'h00080,
    S_TD    = 20'h00100,
    S_DIVT  = 20'h00200,
    S_EF    = 20'h00400,
    S_EG    = 20'h00800,
    S_C1    = 20'h01000,
    S_C2    = 20'h02000,
    S_C3    = 20'h04000,
    S_C4    = 20'h08000,
    S_CM    = 20'h10000,
    S_CN    = 20'h20000,
    S_DIVC  = 20'h40000,
    S_DONE  = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]  model_r;
  logic [23:0] near_r, far_r;
  logic [15:0] roll_r;
  logic [4:0]  count_r;

  logic [23:0] d_r, d_nxt;
  logic [19:0] res_r, res_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [3:0]  n_r, n_nxt;
  logic [29:0] y_r, y_nxt;
  logic [30:0] term_r, term_nxt;
  logic [32:0] pos_r, pos_nxt, neg_r, neg_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [23:0] prev_dist_r, prev_dist_nxt;
  logic [15:0] prev_gain_r, prev_gain_nxt;
  logic [15:0] last_gain_r, last_gain_nxt;
  logic [15:0] g0_r, g0_nxt, gdiff_r, gdiff_nxt;
  logic        up_r, up_nxt;
  logic [23:0] off_r, off_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_gain_r, out_gain_nxt;

  logic [30:0] mul_a;
  logic [29:0] mul_b;
  logic [60:0] mul_r;

  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [39:0] ram_rdata;
  logic [23:0] rd_dist, seg_span;
  logic [15:0] rd_gain;

  div_req_t    div_req;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic        div_done;
  logic [QL-1:0] div_quo;

  logic [23:0] d_m_near, far_m_d, span_lin;
  logic [24:0] sum_lim;
  logic [CNTW-1:0] cnt_ext, c_eff, idx_ext;
  logic [AW-1:0] last_addr;
  logic [4:0]  sh_lo, sh_hi;
  logic [33:0] exp_rnd;
  logic        in_acc;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  assign d_m_near = d_r - near_r;
  assign far_m_d  = far_r - d_r;
  assign span_lin = far_r - near_r;
  assign sum_lim  = {1'b0, near_r} + {1'b0, far_r};

  // Clamp the point count to the table depth
  assign cnt_ext   = CNTW'(count_r);
  assign c_eff     = (cnt_ext > CNTW'(CURVE_DEPTH)) ? CNTW'(CURVE_DEPTH) : cnt_ext;
  assign last_addr = AW'(c_eff - CNTW'(1));
  assign idx_ext   = CNTW'(idx_r);

  assign rd_dist  = ram_rdata[39:16];
  assign rd_gain  = ram_rdata[15:0];
  assign seg_span = rd_dist - prev_dist_r;

  assign sh_lo   = 5'(n_r) + 5'd14;
  assign sh_hi   = 5'(n_r) + 5'd15;
  assign exp_rnd = 34'(pos_r) + (34'd1 << sh_lo);

  // Store curve writes; entries past the depth are dropped
  assign ram_we    = in_acc && in_action && (32'(in_point_index) < CURVE_DEPTH);
  assign ram_waddr = AW'(in_point_index);

  dag_ram #(.WIDTH(40), .DEPTH(CURVE_DEPTH), .AW(AW)) u_curve (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({in_distance_in, in_point_gain}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dag_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    mul_r <= 61'(mul_a) * 61'(mul_b);
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    res_nxt       = res_r;
    den_nxt       = den_r;
    n_nxt         = n_r;
    y_nxt         = y_r;
    term_nxt      = term_r;
    pos_nxt       = pos_r;
    neg_nxt       = neg_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    prev_dist_nxt = prev_dist_r;
    prev_gain_nxt = prev_gain_r;
    last_gain_nxt = last_gain_r;
    g0_nxt        = g0_r;
    gdiff_nxt     = gdiff_r;
    up_nxt        = up_r;
    off_nxt       = off_r;
    mul_a         = '0;
    mul_b         = '0;
    ram_raddr     = '0;
    div_req       = '{start: 1'b0, long_op: 1'b0};
    div_num       = '0;
    div_den       = '0;
    out_valid_nxt = out_valid_r;
    out_gain_nxt  = out_gain_r;

    // Drop the held beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && !in_action) begin
          d_nxt     = in_distance_in;
          state_nxt = S_DISP;
        end
      end

      S_DISP: begin
        res_nxt   = 20'(ONE_Q15);
        state_nxt = S_DONE;
        if (d_r <= near_r) begin
          res_nxt = 20'(ONE_Q15);
        end else if (d_r >= far_r) begin
          res_nxt = '0;
        end else begin
          case (model_r)
            MODEL_LINEAR: begin
              if (span_lin != '0) begin
                div_num   = 48'({far_m_d, 15'd0}) + 48'(span_lin >> 1);
                div_den   = DEN_W'(span_lin);
                div_req   = '{start: 1'b1, long_op: 1'b0};
                state_nxt = S_DIVG;
              end
            end
            MODEL_INVERSE: begin
              mul_a     = 31'(roll_r);
              mul_b     = 30'(d_m_near);
              state_nxt = S_INV;
            end
            MODEL_EXP: begin
              if (sum_lim != '0) begin
                div_num   = 48'({d_m_near, 18'd0}) + 48'(sum_lim >> 1);
                div_den   = DEN_W'(sum_lim);
                div_req   = '{start: 1'b1, long_op: 1'b0};
                state_nxt = S_DIVX;
              end
            end
            MODEL_CUSTOM: begin
              if (c_eff != '0) begin
                ram_raddr = '0;
                state_nxt = S_C1;
              end
            end
            default: begin
              res_nxt = 20'(ONE_Q15);
            end
          endcase
        end
      end

      // Inverse distance: form the divisor, then divide
      S_INV: begin
        den_nxt   = DEN_W'({near_r, 8'd0}) + DEN_W'(mul_r[39:0]);
        state_nxt = S_INV2;
      end

      S_INV2: begin
        if (den_r == '0) begin
          res_nxt   = 20'(ONE_Q15);
          state_nxt = S_DONE;
        end else begin
          div_num   = 48'({near_r, 23'd0}) + 48'(den_r >> 1);
          div_den   = den_r;
          div_req   = '{start: 1'b1, long_op: 1'b0};
          state_nxt = S_DIVG;
        end
      end

      S_DIVG: begin
        if (div_done) begin
          res_nxt   = div_quo[19:0];
          state_nxt = S_DONE;
        end
      end

      // Exponential: split x into integer and fraction, scale by ln2
      S_DIVX: begin
        mul_a = 31'(div_quo[15:0]);
        mul_b = LN2_Q30;
        if (div_done) begin
          n_nxt     = 4'(div_quo[18:16]);
          state_nxt = S_EY;
        end
      end

      S_EY: begin
        y_nxt     = mul_r[45:16];
        term_nxt  = ONE_Q30;
        pos_nxt   = 33'(ONE_Q30);
        neg_nxt   = '0;
        k_nxt     = 4'd1;
        state_nxt = S_TM;
      end

      S_TM: begin
        mul_a     = term_r;
        mul_b     = y_r;
        state_nxt = S_TD;
      end

      S_TD: begin
        div_num   = 48'(mul_r[60:30]);
        div_den   = DEN_W'(k_r);
        div_req   = '{start: 1'b1, long_op: 1'b1};
        state_nxt = S_DIVT;
      end

      // Accumulate one series term, odd terms negative
      S_DIVT: begin
        if (div_done) begin
          term_nxt = div_quo[30:0];
          if (k_r[0]) begin
            neg_nxt = neg_r + 33'(div_quo[30:0]);
          end else begin
            pos_nxt = pos_r + 33'(div_quo[30:0]);
          end
          if (k_r == 4'd10) begin
            state_nxt = S_EF;
          end else begin
            k_nxt     = k_r + 4'd1;
            state_nxt = S_TM;
          end
        end
      end

      S_EF: begin
        pos_nxt   = (pos_r > neg_r) ? (pos_r - neg_r) : '0;
        state_nxt = S_EG;
      end

      S_EG: begin
        res_nxt   = 20'(exp_rnd >> sh_hi);
        state_nxt = S_DONE;
      end

      // Custom: check below the first point
      S_C1: begin
        if (d_r <= rd_dist) begin
          res_nxt   = 20'(rd_gain);
          state_nxt = S_DONE;
        end else begin
          ram_raddr = last_addr;
          state_nxt = S_C2;
        end
      end

      // Check beyond the last point
      S_C2: begin
        last_gain_nxt = rd_gain;
        if (d_r >= rd_dist) begin
          res_nxt   = 20'(rd_gain);
          state_nxt = S_DONE;
        end else begin
          ram_raddr = '0;
          state_nxt = S_C3;
        end
      end

      S_C3: begin
        prev_dist_nxt = rd_dist;
        prev_gain_nxt = rd_gain;
        idx_nxt       = AW'(1);
        ram_raddr     = AW'(1);
        state_nxt     = S_C4;
      end

      // Walk segments until the distance falls inside one
      S_C4: begin
        if (d_r >= prev_dist_r && d_r <= rd_dist) begin
          if (seg_span == '0) begin
            res_nxt   = 20'(ONE_Q15);
            state_nxt = S_DONE;
          end else begin
            g0_nxt    = prev_gain_r;
            up_nxt    = rd_gain >= prev_gain_r;
            gdiff_nxt = (rd_gain >= prev_gain_r) ? (rd_gain - prev_gain_r)
                                                 : (prev_gain_r - rd_gain);
            off_nxt   = d_r - prev_dist_r;
            den_nxt   = DEN_W'(seg_span);
            state_nxt = S_CM;
          end
        end else if ((idx_ext + CNTW'(1)) < c_eff) begin
          prev_dist_nxt = rd_dist;
          prev_gain_nxt = rd_gain;
          idx_nxt       = idx_r + AW'(1);
          ram_raddr     = idx_r + AW'(1);
        end else begin
          res_nxt   = 20'(last_gain_r);
          state_nxt = S_DONE;
        end
      end

      S_CM: begin
        mul_a     = 31'(gdiff_r);
        mul_b     = 30'(off_r);
        state_nxt = S_CN;
      end

      S_CN: begin
        div_num   = 48'(mul_r[39:0]) + 48'(den_r >> 1);
        div_den   = den_r;
        div_req   = '{start: 1'b1, long_op: 1'b0};
        state_nxt = S_DIVC;
      end

      S_DIVC: begin
        if (div_done) begin
          res_nxt   = up_r ? (20'(g0_r) + 20'(div_quo[18:0]))
                           : (20'(g0_r) - 20'(div_quo[18:0]));
          state_nxt = S_DONE;
        end
      end

      // Hand the gain to the output register, saturated to 1.0
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_gain_nxt  = (res_r > 20'(ONE_Q15)) ? ONE_Q15 : res_r[15:0];
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      model_r     <= MODEL_INVERSE;
      near_r      <= 24'd256;
      far_r       <= 24'd25600;
      roll_r      <= 16'd256;
      count_r     <= 5'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      // Configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODEL:   model_r <= cfg_data[2:0];
          REG_NEAR:    near_r  <= cfg_data;
          REG_FAR:     far_r   <= cfg_data;
          REG_ROLLOFF: roll_r  <= cfg_data[15:0];
          REG_COUNT:   count_r <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
    d_r         <= d_nxt;
    res_r       <= res_nxt;
    den_r       <= den_nxt;
    n_r         <= n_nxt;
    y_r         <= y_nxt;
    term_r      <= term_nxt;
    pos_r       <= pos_nxt;
    neg_r       <= neg_nxt;
    k_r         <= k_nxt;
    idx_r       <= idx_nxt;
    prev_dist_r <= prev_dist_nxt;
    prev_gain_r <= prev_gain_nxt;
    last_gain_r <= last_gain_nxt;
    g0_r        <= g0_nxt;
    gdiff_r     <= gdiff_nxt;
    up_r        <= up_nxt;
    off_r       <= off_nxt;
    out_gain_r  <= out_gain_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_gain_out = out_gain_r;

  // Gain never exceeds 1.0
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_gain_out <= ONE_Q15)
    else $error("gain above 1.0");

  // An evaluate beat closes the input until its result is handed over
  a_busy_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_action) |=> !in_ready)
    else $error("input open while evaluating");

  // Divider completes only while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVG || state_r == S_DIVX ||
                  state_r == S_DIVT || state_r == S_DIVC))
    else $error("divider result with no consumer");

  // A new result beat comes only from the hand-over state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result beat from wrong state");

endmodule

// ===== design/dag_ram.sv =====
module dag_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/dag_sdiv.sv =====
module dag_sdiv import dag_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QL-1:0]    quo
);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] sr_r, sr_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [QL-1:0]    q_r, q_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One quotient bit per cycle: shift in the next dividend bit, try subtract
  assign trial = {rem_r, sr_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    sr_nxt   = sr_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      // Preload the bits above the quotient range; they stay below the divisor
      den_nxt  = den;
      q_nxt    = '0;
      busy_nxt = 1'b1;
      if (req.long_op) begin
        rem_nxt = DEN_W'(num >> QL);
        sr_nxt  = num << (NUM_W - QL);
        cnt_nxt = 6'(QL);
      end else begin
        rem_nxt = DEN_W'(num >> QS);
        sr_nxt  = num << (NUM_W - QS);
        cnt_nxt = 6'(QS);
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sr_nxt  = sr_r << 1;
      q_nxt   = {q_r[QL-2:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    sr_r  <= sr_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import dag_pkg::*; ();

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [23:0] in_distance_in = '0;
  logic [3:0]  in_point_index = '0;
  logic [15:0] in_point_gain = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_gain_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  localparam int TABLE_DEPTH = 16;
  localparam int STALL_LIMIT = 6000;
  localparam logic ACT_EVAL  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  distance_attenuation_gain u_dut (.*);

  always #4 clk = ~clk;

  // Shadow copy of the registers and the curve table
  logic [2:0]  sh_model;
  logic [23:0] sh_near, sh_far;
  logic [15:0] sh_rolloff;
  logic [4:0]  sh_count;
  logic [23:0] pt_dist [TABLE_DEPTH];
  logic [15:0] pt_gain [TABLE_DEPTH];

  logic [15:0] gains_due [$];
  int          err_cnt = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  typedef struct {
    logic [2:0]  model;
    logic [23:0] near_d;
    logic [23:0] far_d;
    logic [15:0] rolloff;
    logic [4:0]  count;
    logic [23:0] dist_in;
    int          gain_ref;  // -1: take the predicted gain
  } row_t;

  row_t rows [$];

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  // Append one stimulus row
  task automatic add_row(input row_t row);
    rows = {rows, row};
  endtask

  function automatic logic [63:0] div_rnd(input logic [63:0] num, input logic [63:0] den);
    return (num + (den >> 1)) / den;
  endfunction

  // Compute the expected gain for one distance under the shadow state
  function automatic logic [15:0] predict_gain(input logic [23:0] d);
    logic [63:0] num, den, x, y, term, pos, neg, r, span, off, g;
    int          n, c;
    if (d <= sh_near) return ONE_Q15;
    if (d >= sh_far) return 16'd0;
    g = 64'(ONE_Q15);
    case (sh_model)
      MODEL_LINEAR: begin
        span = 64'(sh_far) - 64'(sh_near);
        if (span != 0) g = div_rnd(64'(sh_far - d) * 32768, span);
      end
      MODEL_INVERSE: begin
        num = 64'(sh_near) << 8;
        den = num + 64'(sh_rolloff) * 64'(d - sh_near);
        if (den != 0) g = div_rnd(num * 32768, den);
      end
      MODEL_EXP: begin
        den = 64'(sh_near) + 64'(sh_far);
        if (den != 0) begin
          x = div_rnd(64'(d - sh_near) << 18, den);
          n = int'(x >> 16);
          if (n > 8) n = 8;
          y = ((x & 64'hFFFF) * 64'(LN2_Q30)) >> 16;
          pos = 64'd1 << 30;
          neg = 0;
          term = 64'd1 << 30;
          for (int k = 1; k <= 10; k++) begin
            term = ((term * y) >> 30) / k;
            if (k % 2 == 1) neg += term;
            else pos += term;
          end
          r = (pos > neg) ? pos - neg : 0;
          g = (r + (64'd1 << (14 + n))) >> (15 + n);
        end
      end
      MODEL_CUSTOM: begin
        c = (sh_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(sh_count);
        if (c != 0) begin
          if (d <= pt_dist[0]) g = pt_gain[0];
          else if (d >= pt_dist[c-1]) g = pt_gain[c-1];
          else begin
            g = pt_gain[c-1];
            for (int i = 0; i + 1 < c; i++) begin
              if (d >= pt_dist[i] && d <= pt_dist[i+1]) begin
                span = 64'(pt_dist[i+1] - pt_dist[i]);
                off = 64'(d - pt_dist[i]);
                if (span == 0) g = 64'(ONE_Q15);
                else if (pt_gain[i+1] >= pt_gain[i])
                  g = pt_gain[i] + div_rnd(64'(pt_gain[i+1] - pt_gain[i]) * off, span);
                else
                  g = pt_gain[i] - div_rnd(64'(pt_gain[i] - pt_gain[i+1]) * off, span);
                break;
              end
            end
          end
        end
      end
      default: g = 64'(ONE_Q15);
    endcase
    if (g > 64'(ONE_Q15)) g = 64'(ONE_Q15);
    return g[15:0];
  endfunction

  // Send one beat after the burst gap, then record its effect
  task automatic send_beat(input logic act, input logic [23:0] d_in, input logic [3:0] idx,
                           input logic [15:0] pg, input int gain_ref);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_distance_in <= d_in;
    in_point_index <= idx;
    in_point_gain  <= pg;
    do @(posedge clk); while (!in_ready);
    if (act == ACT_WRITE) begin
      pt_dist[idx] = d_in;
      pt_gain[idx] = pg;
    end else begin
      gains_due = {gains_due, (gain_ref >= 0 ? 16'(gain_ref) : predict_gain(d_in))};
    end
  endtask

  // Hold the input and wait until every gain has come back
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (gains_due.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_cfg(input logic [2:0] m, input logic [23:0] nr, input logic [23:0] fr,
                           input logic [15:0] ro, input logic [4:0] cnt);
    drain();
    write_reg(REG_MODEL, 24'(m));
    write_reg(REG_NEAR, nr);
    write_reg(REG_FAR, fr);
    write_reg(REG_ROLLOFF, 24'(ro));
    write_reg(REG_COUNT, 24'(cnt));
    cfg_valid <= 1'b0;
    sh_model = m; sh_near = nr; sh_far = fr; sh_rolloff = ro; sh_count = cnt;
  endtask

  function automatic logic [23:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 1023));
      3: return 24'($urandom_range(0, 65535));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_dist();
    logic [23:0] lo, hi;
    lo = (sh_near < sh_far) ? sh_near : sh_far;
    hi = (sh_near < sh_far) ? sh_far : sh_near;
    case ($urandom_range(0, 9))
      0: return 24'($urandom);
      1: return sh_near + 24'($urandom_range(0, 2)) - 24'd1;
      2: return sh_far + 24'($urandom_range(0, 2)) - 24'd1;
      3: return pt_dist[$urandom_range(0, TABLE_DEPTH - 1)] + 24'($urandom_range(0, 2)) - 24'd1;
      default: return 24'($urandom_range(int'(lo), int'(hi)));
    endcase
  endfunction

  // Reload the curve table, mostly ascending, sometimes unordered or repeated
  task automatic reload_curve();
    logic [23:0] step, pos;
    int          shape;
    shape = $urandom_range(0, 5);
    step = 24'($urandom_range(1, 4000));
    pos = sh_near + 24'($urandom_range(0, 300));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (shape == 0) pos = 24'($urandom);
      else if (shape != 1 || $urandom_range(0, 2) != 0) pos = pos + step;
      send_beat(ACT_WRITE, pos, 4'(i),
                ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
                -1);
    end
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (gains_due.size() == 0) begin
        report($sformatf("unexpected gain %0d", out_gain_out));
      end else begin
        if (out_gain_out !== gains_due[0])
          report($sformatf("gain %0d, expected %0d", out_gain_out, gains_due[0]));
        void'(gains_due.pop_front());
      end
    end
  end

  // Receiver stalls in runs, with long stretches of steady ready
  int rdy_left = 0;
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      case ($urandom_range(0, 3))
        0: begin out_ready <= 1'b1; rdy_left = $urandom_range(50, 200); end
        1: begin out_ready <= 1'b0; rdy_left = $urandom_range(1, 20); end
        default: begin out_ready <= $urandom_range(0, 1); rdy_left = $urandom_range(1, 6); end
      endcase
    end else begin
      rdy_left--;
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else if (rst_n) begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [2:0] m;
    logic [23:0] nr, fr;
    int          num_beats;
    sh_model = MODEL_INVERSE; sh_near = 24'd256; sh_far = 24'd25600;
    sh_rolloff = 16'd256; sh_count = 5'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Defaults after reset
    add_row('{MODEL_INVERSE, 256, 25600, 256, 0, 24'd0, 32768});
    add_row('{MODEL_INVERSE, 256, 25600, 256, 0, 24'd256, 32768});
    add_row('{MODEL_INVERSE, 256, 25600, 256, 0, 24'd25600, 0});
    add_row('{MODEL_INVERSE, 256, 25600, 256, 0, 24'hFFFFFF, 0});
    add_row('{MODEL_INVERSE, 256, 25600, 256, 0, 24'd1000, -1});
    // Each model, crossed limits, zero divisors, unknown model, custom table
    add_row('{MODEL_NONE, 256, 25600, 256, 0, 24'd5000, 32768});
    add_row('{MODEL_LINEAR, 256, 25600, 256, 0, 24'd12928, -1});
    add_row('{MODEL_EXP, 256, 25600, 256, 0, 24'd3000, -1});
    add_row('{MODEL_EXP, 0, 0, 256, 0, 24'd0, 32768});
    add_row('{MODEL_LINEAR, 1000, 500, 256, 0, 24'd700, 32768});
    add_row('{3'd7, 256, 25600, 256, 0, 24'd5000, 32768});
    add_row('{MODEL_INVERSE, 0, 25600, 0, 0, 24'd100, 32768});
    add_row('{MODEL_INVERSE, 256, 25600, 16'hFFFF, 0, 24'd2000, -1});
    add_row('{MODEL_LINEAR, 0, 24'hFFFFFF, 256, 0, 24'hFFFFFE, -1});
    add_row('{MODEL_CUSTOM, 256, 25600, 256, 0, 24'd5000, 32768});
    add_row('{MODEL_CUSTOM, 256, 25600, 256, 16, 24'd5000, -1});
    add_row('{MODEL_CUSTOM, 256, 25600, 256, 31, 24'd9000, -1});
    add_row('{MODEL_CUSTOM, 0, 24'hFFFFFF, 256, 16, 24'd1, -1});
    add_row('{MODEL_CUSTOM, 0, 24'hFFFFFF, 256, 16, 24'd30000, -1});

    foreach (rows[r]) begin
      if (r == 5) begin
        // Load an ascending curve; the first point's gain is over range
        for (int i = 0; i < TABLE_DEPTH; i++)
          send_beat(ACT_WRITE, 24'(256 + i * 1500), 4'(i),
                    (i == 0) ? 16'd40000 : 16'(32768 - i * 2000), -1);
      end
      if (rows[r].model != sh_model || rows[r].near_d != sh_near || rows[r].far_d != sh_far ||
          rows[r].rolloff != sh_rolloff || rows[r].count != sh_count)
        apply_cfg(rows[r].model, rows[r].near_d, rows[r].far_d, rows[r].rolloff, rows[r].count);
      send_beat(ACT_EVAL, rows[r].dist_in, 4'd0, 16'd0, rows[r].gain_ref);
    end

    // Random phases, each under its own register setting
    num_beats = 0;
    for (int ph = 0; num_beats < 1200; ph++) begin
      m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      nr = pick_limit();
      fr = ($urandom_range(0, 4) == 0) ? pick_limit() : nr + 24'($urandom_range(1, 100000));
      apply_cfg(m, nr, fr,
                ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
                                            : 16'($urandom),
                ($urandom_range(0, 5) == 0) ? 5'($urandom_range(17, 31))
                                            : 5'($urandom_range(0, 16)));
      if (m == MODEL_CUSTOM) reload_curve();
      for (int k = 0; k < 120; k++) begin
        if ($urandom_range(0, 19) == 0)
          send_beat(ACT_WRITE, 24'($urandom), 4'($urandom), 16'($urandom), -1);
        else
          send_beat(ACT_EVAL, pick_dist(), 4'($urandom), 16'($urandom), -1);
        num_beats++;
        // Let the pipeline empty once in mid phase
        if (ph == 2 && k == 60) drain();
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/dag_pkg.sv
design/dag_ram.sv
design/dag_sdiv.sv
design/distance_attenuation_gain.sv
tb/tb_top.sv
